[rtl/core/okst_pkg.sv]
package okst_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CAPACITY);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_HIT      = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef enum logic [1:0] {
        RES_INSERTED,
        RES_FULL,
        RES_FIND
    } okst_res_t;

    typedef enum logic {
        RD_MID,
        RD_SHIFT
    } okst_rd_sel_t;

    typedef struct packed {
        logic         load;
        logic         step;
        okst_rd_sel_t rd_sel;
        logic         shift_wr;
        logic         put;
        logic         respond;
        okst_res_t    res_kind;
    } okst_cmd_t;

    typedef struct packed {
        logic search_done;
        logic shift_done;
        logic full;
        logic out_free;
    } okst_stat_t;

endpackage

[rtl/core/ordered_key_store_floor_lookup_core.sv]
// A find over n stored keys takes k <= floor(log2(n))+1 search steps, each a read and a compare;
// when the search ends, the result is registered and the next request is taken back in idle.
// An insert that moves s entries up adds one read and one write per entry, then puts the key;
// a refused insert skips the search and goes straight to the response.
// One request is worked at a time; a new one is taken while the last result waits.
// Reset empties the store and the output register; memory contents are left as they are.
module ordered_key_store_floor_lookup_core
    import okst_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic                    cmd,
    input  logic signed [KEY_W-1:0] key,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic signed [KEY_W-1:0] found_key,
    output logic [1:0]              status
);

    okst_cmd_t  ctl;
    okst_stat_t stat;

    okst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .cmd      (cmd),
        .req_stall(req_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    okst_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key),
        .ctl      (ctl),
        .stat     (stat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .found_key(found_key),
        .status   (status)
    );

endmodule

[rtl/core/okst_ram.sv]
module okst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/okst_ctrl.sv]
module okst_ctrl
    import okst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       cmd,
    output logic       req_stall,
    input  okst_stat_t stat,
    output okst_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RESP
    } state_t;

    state_t    state_reg, state_next;
    logic      find_reg, find_next;
    okst_res_t kind_reg, kind_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        find_next    = find_reg;
        kind_next    = kind_reg;
        ctl          = '0;
        ctl.rd_sel   = RD_MID;
        ctl.res_kind = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load  = 1'b1;
                    find_next = (cmd == CMD_FIND);
                    if (cmd == CMD_INSERT && stat.full)
                    begin
                        kind_next  = RES_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SEARCH_RD;
                    end
                end
            end
            S_SEARCH_RD:
            begin
                if (!stat.search_done)
                begin
                    state_next = S_SEARCH_CMP;
                end
                else if (find_reg)
                begin
                    kind_next  = RES_FIND;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SEARCH_CMP:
            begin
                ctl.step   = 1'b1;
                state_next = S_SEARCH_RD;
            end
            S_SHIFT_RD:
            begin
                ctl.rd_sel = RD_SHIFT;
                state_next = stat.shift_done ? S_PUT : S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_PUT:
            begin
                ctl.put    = 1'b1;
                kind_next  = RES_INSERTED;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            find_reg  <= 1'b0;
            kind_reg  <= RES_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            find_reg  <= find_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[rtl/core/okst_dp.sv]
module okst_dp
    import okst_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [KEY_W-1:0] key,
    input  okst_cmd_t               ctl,
    output okst_stat_t              stat,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic signed [KEY_W-1:0] found_key,
    output logic [1:0]              status
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] floor_reg, floor_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [KEY_W-1:0] found_reg, found_next;
    logic [1:0]       status_reg, status_next;

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] rd_addr;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [KEY_W-1:0] ram_rdata;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign rd_addr = (ctl.rd_sel == RD_SHIFT) ? idx_dec : mid;

    assign ram_we    = ctl.shift_wr | ctl.put;
    assign ram_waddr = ctl.put ? lo_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign ram_wdata = ctl.put ? key_reg : ram_rdata;

    okst_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_addr[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    assign stat.search_done = (lo_reg == hi_reg);
    assign stat.shift_done  = (idx_reg == lo_reg);
    assign stat.full        = (count_reg == CNT_FULL);
    assign stat.out_free    = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        key_next       = key_reg;
        floor_next     = floor_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (ctl.load)
        begin
            key_next = key ^ SIGN_FLIP;
            lo_next  = '0;
            hi_next  = count_reg;
            idx_next = count_reg;
        end
        if (ctl.step)
        begin
            if (ram_rdata <= key_reg)
            begin
                lo_next    = mid + CNT_W'(1);
                floor_next = ram_rdata;
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (ctl.shift_wr)
        begin
            idx_next = idx_dec;
        end
        if (ctl.put)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctl.respond)
        begin
            rsp_valid_next = 1'b1;
            case (ctl.res_kind)
                RES_INSERTED:
                begin
                    found_next  = '0;
                    status_next = ST_INSERTED;
                end
                RES_FULL:
                begin
                    found_next  = '0;
                    status_next = ST_FULL;
                end
                default:
                begin
                    if (lo_reg == '0)
                    begin
                        found_next  = '0;
                        status_next = ST_NONE;
                    end
                    else
                    begin
                        found_next  = floor_reg ^ SIGN_FLIP;
                        status_next = ST_HIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        floor_reg  <= floor_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign found_key = $signed(found_reg);
    assign status    = status_reg;

endmodule

[sim/tb_ordered_key_store_floor_lookup_core.sv]
module tb_ordered_key_store_floor_lookup_core
    import okst_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_REQS = 290;
    localparam int CYCLE_LIMIT = 3_000_000;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic signed [KEY_W-1:0] found;
        logic [1:0]              st;
    } answer_t;

    // Keeps a sorted copy of the stored keys and the answers still owed by the block.
    class key_store_scoreboard;
        logic signed [KEY_W-1:0] sorted_copy[$];
        answer_t                 pending_answers[$];
        int                      mismatches;
        int                      inserted;
        int                      refused;
        int                      floors;
        int                      misses;

        function new();
            mismatches = 0;
            inserted   = 0;
            refused    = 0;
            floors     = 0;
            misses     = 0;
        endfunction

        // Number of stored keys that are less than or equal to k.
        function int unsigned upper_pos(logic signed [KEY_W-1:0] k);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = sorted_copy.size();
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (sorted_copy[mid] <= k)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void note_request(logic c, logic signed [KEY_W-1:0] k);
            answer_t     a;
            int unsigned pos;
            pos     = upper_pos(k);
            a.found = '0;
            if (c == CMD_INSERT)
            begin
                if (sorted_copy.size() >= CAPACITY)
                begin
                    a.st = ST_FULL;
                    refused++;
                end
                else
                begin
                    sorted_copy.insert(pos, k);
                    a.st = ST_INSERTED;
                    inserted++;
                end
            end
            else if (pos == 0)
            begin
                a.st = ST_NONE;
                misses++;
            end
            else
            begin
                a.found = sorted_copy[pos - 1];
                a.st    = ST_HIT;
                floors++;
            end
            pending_answers.push_back(a);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: %s", mismatches, what);
        endfunction

        function void check_answer(logic signed [KEY_W-1:0] found, logic [1:0] st);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                flag($sformatf("result with no request outstanding: found_key %0d status %0d",
                               found, st));
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found)
                flag($sformatf("found_key expected %0d got %0d", want.found, found));
            if (st !== want.st)
                flag($sformatf("status expected %0d got %0d", want.st, st));
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic                    cmd       = CMD_INSERT;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    rsp_valid;
    logic                    rsp_stall = 1'b0;
    logic signed [KEY_W-1:0] found_key;
    logic [1:0]              status;

    logic                    calm      = 1'b0;
    logic                    hold_on   = 1'b0;
    bit                      hold_go   = 1'b0;
    int                      cycles    = 0;
    key_store_scoreboard     sb;

    ordered_key_store_floor_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .found_key (found_key),
        .status    (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_answer(found_key, status);
        if (hold_on)
            rsp_stall <= 1'b1;
        else if (calm)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // The receiver holds off for a long stretch so that results back up and requests stall.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    task automatic send_request(input logic c, input logic signed [KEY_W-1:0] k);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= c;
        key       <= k;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(c, k);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_answers.size() != 0);
    endtask

    function automatic logic signed [KEY_W-1:0] near_stored();
        logic signed [KEY_W-1:0] k;
        if (sb.sorted_copy.size() == 0)
            return $urandom;
        k = sb.sorted_copy[$urandom_range(0, sb.sorted_copy.size() - 1)];
        case ($urandom_range(0, 3))
            0:       return k - 1;
            1:       return k + 1;
            default: return k;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] any_key();
        int unsigned r;
        int          s;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom;
        if (r < 75)
        begin
            s = int'($urandom_range(0, 40)) - 20;
            return s;
        end
        if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return near_stored();
    endfunction

    initial
    begin
        logic signed [KEY_W-1:0] fill;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Finds on an empty store, then extremes, duplicates and floors below every key.
        send_request(CMD_FIND, '0);
        send_request(CMD_FIND, KEY_MIN);
        send_request(CMD_FIND, KEY_MAX);
        send_request(CMD_INSERT, '0);
        send_request(CMD_FIND, '0);
        send_request(CMD_FIND, -1);
        send_request(CMD_FIND, 5);
        send_request(CMD_INSERT, KEY_MAX);
        send_request(CMD_INSERT, KEY_MIN);
        send_request(CMD_FIND, KEY_MIN);
        send_request(CMD_FIND, KEY_MAX);
        send_request(CMD_FIND, KEY_MAX - 1);
        send_request(CMD_INSERT, '0);
        send_request(CMD_INSERT, -5);
        send_request(CMD_FIND, -6);
        send_request(CMD_FIND, -5);
        send_request(CMD_FIND, -4);
        send_request(CMD_INSERT, 32'sh5555_5555);
        send_request(CMD_INSERT, 32'shAAAA_AAAA);
        send_request(CMD_FIND, 32'sh5555_5556);
        send_request(CMD_FIND, 32'shAAAA_AAAB);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == 60)
                calm <= 1'b1;
            if (n == 120)
                calm <= 1'b0;
            if (n == 150)
            begin
                hold_go = 1'b1;
                calm   <= 1'b1;
            end
            if (n == 175)
                calm <= 1'b0;
            if (n == 220)
                wait_drained();
            if ($urandom_range(0, 99) < 45)
                send_request(CMD_INSERT, any_key());
            else if ($urandom_range(0, 99) < 60)
                send_request(CMD_FIND, near_stored());
            else
                send_request(CMD_FIND, any_key());
        end

        // Ascending keys near the top shift few entries, so filling the store stays cheap.
        fill = 32'sh7000_0000;
        while (sb.sorted_copy.size() < CAPACITY)
        begin
            fill = fill + $urandom_range(0, 32'h3_FFFF);
            send_request(CMD_INSERT, fill);
        end
        send_request(CMD_INSERT, KEY_MIN);
        send_request(CMD_INSERT, KEY_MAX);
        send_request(CMD_FIND, KEY_MIN);
        send_request(CMD_FIND, KEY_MAX);
        for (int n = 0; n < 12; n++)
        begin
            if (n % 3 == 0)
                send_request(CMD_INSERT, any_key());
            else if (n % 3 == 1)
                send_request(CMD_FIND, near_stored());
            else
                send_request(CMD_FIND, any_key());
        end

        wait_drained();
        repeat (40) @(posedge clk);

        $display("Stored %0d keys up to a full store, refused %0d inserts when full.",
                 sb.inserted, sb.refused);
        $display("Finds: %0d returned a key at or below the query, %0d found none.",
                 sb.floors, sb.misses);
        if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/okst_pkg.sv
rtl/core/okst_ram.sv
rtl/core/okst_ctrl.sv
rtl/core/okst_dp.sv
rtl/core/ordered_key_store_floor_lookup_core.sv
sim/tb_ordered_key_store_floor_lookup_core.sv
